// ----- rtl/core/acea_pkg.sv -----
// ----------------------------------------------------------------------------
// ANSI color escape parser package
// Shared result, job and queue status types, byte codes and the color remap.
// ----------------------------------------------------------------------------
package acea_pkg;

  localparam int unsigned MaxRes  = 4;
  localparam int unsigned CntW    = 3;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = 1;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_ATTR = 1'b1;

  localparam logic [7:0] BYTE_ESC   = 8'd27;
  localparam logic [7:0] BYTE_BSL   = 8'h5c;
  localparam logic [7:0] BYTE_LBR   = 8'h5b;
  localparam logic [7:0] BYTE_M     = 8'h6d;
  localparam logic [7:0] BYTE_SEMI  = 8'h3b;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_ONE   = 8'h31;
  localparam logic [7:0] BYTE_THREE = 8'h33;
  localparam logic [7:0] BYTE_FOUR  = 8'h34;
  localparam logic [7:0] BYTE_SEVEN = 8'h37;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  localparam logic [3:0] CODE_BRBG = 4'd1;
  localparam logic [3:0] CODE_FG   = 4'd3;
  localparam logic [3:0] CODE_BG   = 4'd4;
  localparam logic [3:0] CODE_BRFG = 4'd9;
  localparam logic [3:0] CODE_BAD  = 4'd15;

  localparam logic [15:0] MASK_FG = 16'h00f0;
  localparam logic [15:0] MASK_BG = 16'h000f;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0]     cnt;
    res_t [MaxRes-1:0]   res;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [3:0] color_map(input logic [2:0] d);
    logic [3:0] v;
    case (d)
      3'd0:    v = 4'd0;
      3'd1:    v = 4'd4;
      3'd2:    v = 4'd2;
      3'd3:    v = 4'd6;
      3'd4:    v = 4'd1;
      3'd5:    v = 4'd5;
      3'd6:    v = 4'd3;
      3'd7:    v = 4'd7;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  function automatic res_t mk_text(input logic [7:0] b);
    res_t r;
    r.kind  = KIND_TEXT;
    r.value = {8'd0, b};
    return r;
  endfunction

  function automatic res_t mk_attr(input logic [15:0] v);
    res_t r;
    r.kind  = KIND_ATTR;
    r.value = v;
    return r;
  endfunction

endpackage

// ----- rtl/core/ansi_color_escape_to_attribute.sv -----
// ----------------------------------------------------------------------------
// ANSI color escape to console attribute converter
// Passes text bytes and turns SGR color escapes into attribute words.
//
//   channel  | dir | tdata            | tuser       | tlast
//   s_axis   | in  | [7:0] in_byte    | -           | end_of_stream
//   m_axis   | out | [15:0] out_value | [0] kind    | last
//   cfg      | in  | [15:0] default_attr (cfg_data_i), always ready
//
// Input takes one byte per cycle while the job queue has room; the parser state is registered.
// Each byte yields 0 to 4 result items, one per cycle from the output register while out_ready is high.
// A two-entry job queue lets input continue while results drain.
// Reset clears parser state, queue and output valid; default_attr resets to 7.
// Input stalls only when the job queue is full.
// ----------------------------------------------------------------------------
module ansi_color_escape_to_attribute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] out_value
  output logic        m_axis_tuser,  // [0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import acea_pkg::*;

  logic [15:0] dflt_q, dflt_d;
  logic        push;
  logic        pop;
  job_t        job_in;
  job_t        job_out;
  q_stat_t     q_stat;

  assign cfg_ready_o = 1'b1;
  assign dflt_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : dflt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= 16'd7;
    end else begin
      dflt_q <= dflt_d;
    end
  end

  acea_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_byte_i      (s_axis_tdata),
    .in_eos_i       (s_axis_tlast),
    .default_attr_i (dflt_q),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .job_o          (job_in)
  );

  acea_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .stat_o (q_stat)
  );

  acea_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_value_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  a_stat_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_job_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat.empty |-> (job_out.cnt != 3'd0 && job_out.cnt <= 3'd4))
    else $error("queued job has bad result count");

endmodule

// ----- rtl/core/acea_front.sv -----
// ----------------------------------------------------------------------------
// ANSI color escape parser front end
// Accepts bytes, runs the escape state machine and emits at most one job per accepted byte.
// ----------------------------------------------------------------------------
module acea_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_eos_i,
  input  logic [15:0]      default_attr_i,
  input  acea_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output acea_pkg::job_t   job_o
);
  import acea_pkg::*;

  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_BS      = 9'b000000010,
    M_BS0     = 9'b000000100,
    M_BS03    = 9'b000001000,
    M_ESC     = 9'b000010000,
    M_PFIRST  = 9'b000100000,
    M_PSECOND = 9'b001000000,
    M_PTHIRD  = 9'b010000000,
    M_SEP     = 9'b100000000
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [15:0] attr_q, attr_d;
  logic [3:0]  code_q, code_d;
  logic        halt_q, halt_d;
  logic        accept;
  logic        digit07;
  logic        code_ok;
  job_t        job;

  function automatic logic [15:0] apply_attr(input logic [3:0] code, input logic [2:0] d,
                                             input logic [15:0] ra);
    logic [3:0]  v;
    logic [15:0] r;
    v = color_map(d);
    case (code)
      CODE_FG:   r = {12'd0, v} + (ra & MASK_FG);
      CODE_BG:   r = {8'd0, v, 4'd0} + (ra & MASK_BG);
      CODE_BRFG: r = {12'd0, v | 4'd8} + (ra & MASK_FG);
      default:   r = {8'd0, v | 4'd8, 4'd0} + (ra & MASK_BG);
    endcase
    return r;
  endfunction

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign digit07    = (in_byte_i >= BYTE_ZERO) && (in_byte_i <= BYTE_SEVEN);
  assign code_ok    = (in_byte_i == BYTE_ONE) || (in_byte_i == BYTE_THREE) ||
                      (in_byte_i == BYTE_FOUR) || (in_byte_i == BYTE_NINE);

  always_comb begin
    mode_d = mode_q;
    attr_d = attr_q;
    code_d = code_q;
    halt_d = halt_q;
    job    = '0;
    if (accept && !halt_q) begin
      if (in_eos_i) begin
        case (mode_q)
          M_BS: begin
            job.res[0] = mk_text(BYTE_BSL);
            job.res[1] = mk_attr(default_attr_i);
            job.cnt    = 3'd2;
          end
          M_BS0: begin
            job.res[0] = mk_text(BYTE_BSL);
            job.res[1] = mk_text(BYTE_ZERO);
            job.res[2] = mk_attr(default_attr_i);
            job.cnt    = 3'd3;
          end
          M_BS03: begin
            job.res[0] = mk_text(BYTE_BSL);
            job.res[1] = mk_text(BYTE_ZERO);
            job.res[2] = mk_text(BYTE_THREE);
            job.res[3] = mk_attr(default_attr_i);
            job.cnt    = 3'd4;
          end
          M_ESC: begin
            job.res[0] = mk_text(BYTE_ESC);
            job.res[1] = mk_attr(default_attr_i);
            job.cnt    = 3'd2;
          end
          default: begin
            job.res[0] = mk_attr(default_attr_i);
            job.cnt    = 3'd1;
          end
        endcase
        halt_d = 1'b1;
        mode_d = M_IDLE;
      end else begin
        case (mode_q)
          M_BS: begin
            if (in_byte_i == BYTE_ZERO) begin
              mode_d = M_BS0;
            end else begin
              job.res[0] = mk_text(BYTE_BSL);
              job.res[1] = mk_text(in_byte_i);
              job.cnt    = 3'd2;
              mode_d     = M_IDLE;
            end
          end
          M_BS0: begin
            if (in_byte_i == BYTE_THREE) begin
              mode_d = M_BS03;
            end else begin
              job.res[0] = mk_text(BYTE_BSL);
              job.res[1] = mk_text(BYTE_ZERO);
              job.res[2] = mk_text(in_byte_i);
              job.cnt    = 3'd3;
              mode_d     = M_IDLE;
            end
          end
          M_BS03: begin
            if (in_byte_i == BYTE_THREE) begin
              mode_d = M_ESC;
            end else begin
              job.res[0] = mk_text(BYTE_BSL);
              job.res[1] = mk_text(BYTE_ZERO);
              job.res[2] = mk_text(BYTE_THREE);
              job.res[3] = mk_text(in_byte_i);
              job.cnt    = 3'd4;
              mode_d     = M_IDLE;
            end
          end
          M_ESC: begin
            if (in_byte_i == BYTE_LBR) begin
              attr_d = '0;
              mode_d = M_PFIRST;
            end else begin
              job.res[0] = mk_text(BYTE_ESC);
              job.res[1] = mk_text(in_byte_i);
              job.cnt    = 3'd2;
              mode_d     = M_IDLE;
            end
          end
          M_PFIRST: begin
            if (in_byte_i == BYTE_ZERO) begin
              attr_d = default_attr_i;
              mode_d = M_SEP;
            end else begin
              code_d = code_ok ? in_byte_i[3:0] : CODE_BAD;
              mode_d = M_PSECOND;
            end
          end
          M_PSECOND: begin
            if (digit07 &&
                (code_q == CODE_FG || code_q == CODE_BG || code_q == CODE_BRFG)) begin
              attr_d = apply_attr(code_q, in_byte_i[2:0], attr_q);
              mode_d = M_SEP;
            end else if (digit07 && code_q == CODE_BRBG && in_byte_i == BYTE_ZERO) begin
              mode_d = M_PTHIRD;
            end else begin
              job.res[0] = mk_attr(default_attr_i);
              job.cnt    = 3'd1;
              halt_d     = 1'b1;
              mode_d     = M_IDLE;
            end
          end
          M_PTHIRD: begin
            if (digit07) begin
              attr_d = apply_attr(CODE_BRBG, in_byte_i[2:0], attr_q);
              mode_d = M_SEP;
            end else begin
              job.res[0] = mk_attr(default_attr_i);
              job.cnt    = 3'd1;
              halt_d     = 1'b1;
              mode_d     = M_IDLE;
            end
          end
          M_SEP: begin
            if (in_byte_i == BYTE_SEMI) begin
              mode_d = M_PFIRST;
            end else if (in_byte_i == BYTE_M) begin
              job.res[0] = mk_attr(attr_q);
              job.cnt    = 3'd1;
              mode_d     = M_IDLE;
            end else begin
              mode_d = M_IDLE;
            end
          end
          default: begin
            if (in_byte_i == BYTE_BSL) begin
              mode_d = M_BS;
            end else if (in_byte_i == BYTE_ESC) begin
              mode_d = M_ESC;
            end else begin
              job.res[0] = mk_text(in_byte_i);
              job.cnt    = 3'd1;
              mode_d     = M_IDLE;
            end
          end
        endcase
      end
    end
  end

  assign push_o = (job.cnt != 3'd0);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      attr_q <= '0;
      code_q <= '0;
      halt_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      attr_q <= attr_d;
      code_q <= code_d;
      halt_q <= halt_d;
    end
  end

endmodule

// ----- rtl/core/acea_queue.sv -----
// ----------------------------------------------------------------------------
// ANSI color escape parser job queue
// Short register queue of result jobs between the front and back ends.
// ----------------------------------------------------------------------------
module acea_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  acea_pkg::job_t    job_i,
  input  logic              pop_i,
  output acea_pkg::job_t    job_o,
  output acea_pkg::q_stat_t stat_o
);
  import acea_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QPtrW:0]   cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/acea_back.sv -----
// ----------------------------------------------------------------------------
// ANSI color escape parser back end
// Serializes each job into result items through a registered output stage.
// ----------------------------------------------------------------------------
module acea_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acea_pkg::job_t    job_i,
  input  acea_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_kind_o,
  output logic [15:0]       out_value_o,
  output logic              out_last_o
);
  import acea_pkg::*;

  logic [1:0]  idx_q, idx_d;
  logic        vld_q, vld_d;
  logic        kind_q, kind_d;
  logic [15:0] val_q, val_d;
  logic        last_q, last_d;
  logic        load;
  logic        is_last;
  res_t        cur;

  assign load    = !vld_q || out_ready_i;
  assign cur     = job_i.res[idx_q];
  assign is_last = ({1'b0, idx_q} + 3'd1) == job_i.cnt;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    kind_d = kind_q;
    val_d  = val_q;
    last_d = last_q;
    pop_o  = 1'b0;
    if (load) begin
      vld_d = !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        kind_d = cur.kind;
        val_d  = cur.value;
        last_d = is_last;
        if (is_last) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    val_q  <= val_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_kind_o  = kind_q;
  assign out_value_o = val_q;
  assign out_last_o  = last_q;

endmodule

// ----- verif/ansi_color_escape_to_attribute_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI color escape to attribute converter testbench
// Streams text and SGR color escapes into the converter and predicts every
// text byte and attribute word it should produce. Directed escapes come
// first, then mostly well-formed random escapes with random content, across
// phases with different default attributes and idle/stall patterns. The run
// ends with a randomly chosen stop condition, followed by bytes that must
// produce nothing.
// ----------------------------------------------------------------------------
module ansi_color_escape_to_attribute_tb;
  import acea_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;
  localparam int PhaseItems  = 95;

  localparam logic [3:0] CONSOLE_BITS [8] = '{4'd0, 4'd4, 4'd2, 4'd6,
                                              4'd1, 4'd5, 4'd3, 4'd7};

  localparam logic [7:0] INTRO [25] = '{
    8'h00, 8'hff,
    BYTE_ESC, BYTE_LBR, BYTE_NINE, BYTE_SEVEN, BYTE_SEMI,
    BYTE_ONE, BYTE_ZERO, BYTE_SEVEN, BYTE_M,
    BYTE_BSL, BYTE_ZERO, BYTE_THREE, BYTE_THREE, BYTE_LBR,
    BYTE_ZERO, BYTE_SEMI, BYTE_FOUR, 8'h36, 8'h78,
    BYTE_BSL, BYTE_ZERO, BYTE_THREE, 8'h5a
  };

  typedef enum logic [3:0] {
    PM_IDLE, PM_BS, PM_BS0, PM_BS03, PM_ESC, PM_PFIRST, PM_PSECOND, PM_PTHIRD, PM_SEP
  } parse_mode_e;

  typedef struct {
    logic        kind;
    logic [15:0] value;
    logic        last;
  } console_op_t;

  class sgr_predictor;
    logic [15:0] default_attr;
    parse_mode_e mode;
    logic [15:0] run_attr;
    logic [3:0]  code;
    bit          fg;
    bit          halted;
    console_op_t ops[$];
    console_op_t step_ops[$];
    int          errors;

    function new();
      default_attr = 16'd7;
      mode         = PM_IDLE;
      run_attr     = '0;
      code         = '0;
      fg           = 1'b0;
      halted       = 1'b0;
      errors       = 0;
    endfunction

    function void put(logic kind, logic [15:0] v);
      console_op_t op;
      op.kind  = kind;
      op.value = v;
      op.last  = 1'b0;
      if (step_ops.size() < MaxRes) step_ops.push_back(op);
    endfunction

    function void put_text(logic [7:0] b);
      put(KIND_TEXT, {8'd0, b});
    endfunction

    function void halt_now();
      put(KIND_ATTR, default_attr);
      halted = 1'b1;
      mode   = PM_IDLE;
    endfunction

    function void recolor(logic [3:0] c, logic [2:0] d);
      logic [15:0] v;
      v = {12'd0, CONSOLE_BITS[d]};
      case (c)
        CODE_FG: fg = 1'b1;
        CODE_BG: begin
          fg = 1'b0;
          v  = v << 4;
        end
        CODE_BRFG: begin
          fg = 1'b1;
          v  = v + 16'd8;
        end
        default: begin
          fg = 1'b0;
          v  = (v + 16'd8) << 4;
        end
      endcase
      run_attr = v + (run_attr & (fg ? MASK_FG : MASK_BG));
      mode     = PM_SEP;
    endfunction

    function void note_input(logic [7:0] b, logic eos);
      bit          d07;
      console_op_t op;
      d07 = (b >= BYTE_ZERO) && (b <= BYTE_SEVEN);
      step_ops.delete();
      if (halted) return;
      if (eos) begin
        case (mode)
          PM_BS: put_text(BYTE_BSL);
          PM_BS0: begin
            put_text(BYTE_BSL);
            put_text(BYTE_ZERO);
          end
          PM_BS03: begin
            put_text(BYTE_BSL);
            put_text(BYTE_ZERO);
            put_text(BYTE_THREE);
          end
          PM_ESC: put_text(BYTE_ESC);
          default: ;
        endcase
        halt_now();
      end else begin
        case (mode)
          PM_BS: begin
            if (b == BYTE_ZERO) begin
              mode = PM_BS0;
            end else begin
              put_text(BYTE_BSL);
              put_text(b);
              mode = PM_IDLE;
            end
          end
          PM_BS0: begin
            if (b == BYTE_THREE) begin
              mode = PM_BS03;
            end else begin
              put_text(BYTE_BSL);
              put_text(BYTE_ZERO);
              put_text(b);
              mode = PM_IDLE;
            end
          end
          PM_BS03: begin
            if (b == BYTE_THREE) begin
              mode = PM_ESC;
            end else begin
              put_text(BYTE_BSL);
              put_text(BYTE_ZERO);
              put_text(BYTE_THREE);
              put_text(b);
              mode = PM_IDLE;
            end
          end
          PM_ESC: begin
            if (b == BYTE_LBR) begin
              run_attr = '0;
              mode     = PM_PFIRST;
            end else begin
              put_text(BYTE_ESC);
              put_text(b);
              mode = PM_IDLE;
            end
          end
          PM_PFIRST: begin
            if (b == BYTE_ZERO) begin
              run_attr = default_attr;
              mode     = PM_SEP;
            end else begin
              if (b == BYTE_ONE || b == BYTE_THREE || b == BYTE_FOUR || b == BYTE_NINE)
                code = 4'(b - BYTE_ZERO);
              else
                code = CODE_BAD;
              mode = PM_PSECOND;
            end
          end
          PM_PSECOND: begin
            if (!d07) halt_now();
            else if (code == CODE_FG || code == CODE_BG || code == CODE_BRFG)
              recolor(code, 3'(b - BYTE_ZERO));
            else if (code == CODE_BRBG && b == BYTE_ZERO) mode = PM_PTHIRD;
            else halt_now();
          end
          PM_PTHIRD: begin
            if (d07) recolor(CODE_BRBG, 3'(b - BYTE_ZERO));
            else halt_now();
          end
          PM_SEP: begin
            if (b == BYTE_SEMI) begin
              mode = PM_PFIRST;
            end else if (b == BYTE_M) begin
              put(KIND_ATTR, run_attr);
              mode = PM_IDLE;
            end else begin
              mode = PM_IDLE;
            end
          end
          default: begin
            if (b == BYTE_BSL) begin
              mode = PM_BS;
            end else if (b == BYTE_ESC) begin
              mode = PM_ESC;
            end else begin
              put_text(b);
              mode = PM_IDLE;
            end
          end
        endcase
      end
      foreach (step_ops[i]) begin
        op      = step_ops[i];
        op.last = (i == step_ops.size() - 1);
        ops.push_back(op);
      end
    endfunction

    function void check_output(logic kind, logic [15:0] v, logic last);
      console_op_t want;
      if (ops.size() == 0) begin
        $error("unexpected result: kind %0d value 0x%04h last %0d", kind, v, last);
        errors++;
        return;
      end
      want = ops.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (v !== want.value) begin
        $error("out_value: expected 0x%04h, got 0x%04h", want.value, v);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;

  sgr_predictor sb;
  int           gap_pct   = 0;
  int           stall_pct = 0;
  int           cycles    = 0;

  ansi_color_escape_to_attribute dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL ansi_color_escape_to_attribute");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_output(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(b, eos);
  endtask

  // drop the request line and hold until every expected result is back
  task automatic settle(input int extra);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.ops.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_default(input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.default_attr = v;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] rnd;
    logic [2:0] d;
    rnd = 8'($urandom);
    d   = 3'($urandom);
    case (sb.mode)
      PM_IDLE: begin
        case ($urandom_range(9))
          0, 1, 2: return BYTE_ESC;
          3:       return BYTE_BSL;
          default: return rnd;
        endcase
      end
      PM_BS:           return ($urandom_range(9) < 8) ? BYTE_ZERO : rnd;
      PM_BS0, PM_BS03: return ($urandom_range(9) < 8) ? BYTE_THREE : rnd;
      PM_ESC:          return ($urandom_range(9) < 8) ? BYTE_LBR : rnd;
      PM_PFIRST: begin
        case ($urandom_range(4))
          0:       return BYTE_ZERO;
          1:       return BYTE_ONE;
          2:       return BYTE_THREE;
          3:       return BYTE_FOUR;
          default: return BYTE_NINE;
        endcase
      end
      PM_PSECOND: return (sb.code == CODE_BRBG) ? BYTE_ZERO : 8'(BYTE_ZERO + d);
      PM_PTHIRD:  return 8'(BYTE_ZERO + d);
      default: begin
        case ($urandom_range(9))
          0, 1, 2, 3: return BYTE_SEMI;
          4, 5, 6, 7: return BYTE_M;
          default:    return rnd;
        endcase
      end
    endcase
  endfunction

  // end the stream through one stop condition, then feed bytes that must be ignored
  task automatic finish_stream();
    int         sel;
    logic [7:0] b;
    sel = $urandom_range(9);
    case (sel)
      1: send_byte(BYTE_BSL, 1'b0);
      2: begin
        send_byte(BYTE_BSL, 1'b0);
        send_byte(BYTE_ZERO, 1'b0);
      end
      3: begin
        send_byte(BYTE_BSL, 1'b0);
        send_byte(BYTE_ZERO, 1'b0);
        send_byte(BYTE_THREE, 1'b0);
      end
      4: send_byte(BYTE_ESC, 1'b0);
      5, 6, 7, 8, 9: begin
        send_byte(BYTE_ESC, 1'b0);
        send_byte(BYTE_LBR, 1'b0);
      end
      default: ;
    endcase
    case (sel)
      5: send_byte(BYTE_THREE, 1'b0);
      6: begin
        do b = 8'($urandom);
        while (b inside {BYTE_ZERO, BYTE_ONE, BYTE_THREE, BYTE_FOUR, BYTE_NINE});
        send_byte(b, 1'b0);
        send_byte(8'($urandom), 1'b0);
      end
      7: begin
        send_byte(BYTE_THREE, 1'b0);
        do b = 8'($urandom); while (b >= BYTE_ZERO && b <= BYTE_SEVEN);
        send_byte(b, 1'b0);
      end
      8: begin
        send_byte(BYTE_ONE, 1'b0);
        do b = 8'($urandom); while (b == BYTE_ZERO);
        send_byte(b, 1'b0);
      end
      9: begin
        send_byte(BYTE_ONE, 1'b0);
        send_byte(BYTE_ZERO, 1'b0);
        do b = 8'($urandom); while (b >= BYTE_ZERO && b <= BYTE_SEVEN);
        send_byte(b, 1'b0);
      end
      default: ;
    endcase
    if (sel <= 5) send_byte(8'($urandom), 1'b1);
    repeat (3) send_byte(8'($urandom), 1'($urandom));
  endtask

  initial begin
    int n;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < 25; i++) send_byte(INTRO[i], 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      settle(DrainCycles);
      case (phase)
        0:       write_default(16'hffff);
        1:       write_default(16'h0000);
        2:       write_default(16'($urandom));
        default: write_default(16'h0007);
      endcase
      gap_pct   = (phase == 1) ? 83 : (phase == 3) ? 29 : 0;
      stall_pct = (phase == 2) ? 83 : (phase == 3) ? 29 : 0;
      n = 0;
      while (n < PhaseItems || sb.mode != PM_IDLE) begin
        if (n == PhaseItems / 2) settle(0);
        send_byte(pick_byte(), 1'b0);
        n++;
      end
    end

    finish_stream();
    settle(30);
    if (sb.errors == 0) begin
      $display("PASS ansi_color_escape_to_attribute");
    end else begin
      $display("FAIL ansi_color_escape_to_attribute");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/acea_pkg.sv
rtl/core/acea_front.sv
rtl/core/acea_queue.sv
rtl/core/acea_back.sv
rtl/core/ansi_color_escape_to_attribute.sv
verif/ansi_color_escape_to_attribute_tb.sv
